>>> hw/rtl/kpd_pkg.sv
// ----------------------------------------------------------------------------
// kpd_pkg
// Shared types and constants for the keypoint despike / median / hold filter.
// ----------------------------------------------------------------------------
`default_nettype none

package kpd_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned LikW   = 11;
  localparam int unsigned FrameW = 32;
  localparam int unsigned PidxW  = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 14;

  localparam logic [LikW:0] HoldBonus = 12'd10;
  localparam logic [LikW:0] LikOne    = 12'd1024;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE      = 3'd0,
    REG_USE_CONF  = 3'd1,
    REG_DRAW_CONF = 3'd2,
    REG_DESPIKE   = 3'd3,
    REG_REACQ     = 3'd4,
    REG_MED_LEN   = 3'd5,
    REG_HOLD      = 3'd6,
    REG_NONE      = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_REJECT = 2'd0,
    KIND_MEDIAN = 2'd1,
    KIND_HELD   = 2'd2,
    KIND_PASS   = 2'd3
  } out_kind_e;

  localparam int unsigned ModeFilter  = 0;
  localparam int unsigned ModeConf    = 1;
  localparam int unsigned ModeDespike = 2;
  localparam int unsigned ModeHold    = 3;

endpackage

`default_nettype wire

>>> hw/rtl/keypoint_despike_median_hold_filter.sv
// ----------------------------------------------------------------------------
// keypoint_despike_median_hold_filter
// Per-keypoint despike, running median and hold of tracked pose samples.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one sample per transaction. tuser = point_index. tdata = frame,
//   present, x, y, likelihood. s_axis_tready_o is high only while idle.
//   m_axis: one result per sample; tdata = present, x, y, likelihood,
//   tuser = kind. The result sits in an output register, so the next sample
//   is taken while a result waits; a stalled receiver holds the block only
//   when a second result is ready to be loaded.
//   cfg: register writes (index, data), always ready; write only when idle.
//   Changing any register except the two confidence ones clears point state.
// Path (accept to m_axis_tvalid_o): pass-through, reject and hold go through
//   DECIDE and EMIT, with MDX, MDY, MT and CHECK between them when the
//   despike test runs. A filtered sample adds PUSH, MED and MFIN before EMIT:
//   a rank-count median over the n-entry window (n the window fill, up to
//   MAX_WINDOW), one window-memory read per cycle, x and y in parallel.
//   The despike test squares dx, dy and the threshold on one multiplier.
// Reset: all point state cleared at once, registers to defaults. The window
//   memories need no clearing; only written entries are read.
// ----------------------------------------------------------------------------
`default_nettype none

module keypoint_despike_median_hold_filter #(
  parameter int unsigned NUM_POINTS = 8,
  parameter int unsigned MAX_WINDOW = 31
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // frame[31:0], present[32], x[48:33], y[64:49], likelihood[75:65]
  input  wire logic [79:0]                   s_axis_tdata_i,
  // point_index[2:0]
  input  wire logic [kpd_pkg::PidxW-1:0]     s_axis_tuser_i,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // present[0], x[16:1], y[32:17], likelihood[43:33]
  output logic [47:0]                        m_axis_tdata_o,
  // kind[1:0]
  output logic [1:0]                         m_axis_tuser_o,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [kpd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [kpd_pkg::CfgDataW-1:0]  cfg_data_i
);
  import kpd_pkg::*;

  localparam int unsigned PW    = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
  localparam int unsigned CW    = $clog2(MAX_WINDOW + 1);
  localparam int unsigned DEPTH = NUM_POINTS * MAX_WINDOW;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECIDE, ST_MDX, ST_MDY, ST_MT, ST_CHECK, ST_PUSH, ST_MED,
    ST_MFIN, ST_EMIT
  } state_e;

  state_e state_q;

  // configuration
  logic [3:0]      mode_q;
  logic [LikW-1:0] use_q, draw_q;
  logic [10:0]     desp_q;
  logic [13:0]     reacq_q, hold_q;
  logic [4:0]      mlen_q;

  // point state
  logic [NUM_POINTS-1:0]    has_good_q;
  logic [CoordW-1:0]        gx_q [NUM_POINTS];
  logic [CoordW-1:0]        gy_q [NUM_POINTS];
  logic [FrameW-1:0]        gf_q [NUM_POINTS];
  logic [CW-1:0]            fill_q [NUM_POINTS];
  logic [CW-1:0]            head_q [NUM_POINTS];

  // window memories
  logic [CoordW-1:0] xmem [DEPTH];
  logic [CoordW-1:0] ymem [DEPTH];
  logic [CoordW-1:0] rd_x_q, rd_y_q;
  logic [AW-1:0]     raddr, waddr;

  // latched sample
  logic              inrange_q;
  logic [PW-1:0]     p_q;
  logic [FrameW-1:0] frame_q;
  logic              pres_q;
  logic [CoordW-1:0] x_q, y_q;
  logic [LikW-1:0]   lik_q;

  // arithmetic
  logic signed [17:0] mul_a;
  logic signed [35:0] mul_p;
  logic [35:0]        sum_q, thr_q;

  // median sequencer
  logic [CW-1:0]     n_q, iss_i_q, iss_s_q, d_i_q, d_s_q;
  logic              iss_on_q, d_vld_q;
  logic [CW-1:0]     rank_x_q, rank_y_q, rank_x, rank_y;
  logic [CoordW-1:0] cand_x_q, cand_y_q, lo_x_q, hi_x_q, lo_y_q, hi_y_q;
  logic [CW-1:0]     lo_rank, hi_rank;

  // result
  logic              res_pres_q;
  logic [CoordW-1:0] res_x_q, res_y_q;
  logic [LikW-1:0]   res_lik_q;
  out_kind_e         res_kind_q;
  logic              out_vld_q, out_pres_q;
  logic [CoordW-1:0] out_x_q, out_y_q;
  logic [LikW-1:0]   out_lik_q;
  out_kind_e         out_kind_q;

  // combinational helpers
  logic               good0, hold_ok, reacq, spike;
  logic signed [31:0] gap;
  logic signed [16:0] dx, dy;
  logic [LikW:0]      held_lik, mx;
  logic               hold_pres;
  logic [CoordW-1:0]  hold_x, hold_y;
  logic [LikW-1:0]    hold_lik;
  out_kind_e          hold_kind;
  logic [CW-1:0]      len, h_eff, new_fill;
  logic [AW-1:0]      base;
  logic [CW-1:0]      iss_off;
  logic               x_less, y_less;
  logic signed [16:0] sum_x, sum_y;
  logic               cfg_we, cfg_clr;
  logic [CfgDataW-1:0] cur_val, new_val;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {4'b0, out_lik_q, out_y_q, out_x_q, out_pres_q};
  assign m_axis_tuser_o  = out_kind_q;

  always_comb begin
    good0 = pres_q && (!mode_q[ModeConf] || (lik_q >= use_q));
    gap   = $signed(frame_q - gf_q[p_q]);
    reacq = gap > $signed({18'd0, reacq_q});
    hold_ok = mode_q[ModeHold] && has_good_q[p_q] && (gap <= $signed({18'd0, hold_q}));
    mx = (draw_q > use_q) ? {1'b0, draw_q} : {1'b0, use_q};
    held_lik = mx + HoldBonus;
    if (held_lik > LikOne) held_lik = LikOne;
    hold_pres = inrange_q && hold_ok;
    hold_x    = hold_pres ? gx_q[p_q] : '0;
    hold_y    = hold_pres ? gy_q[p_q] : '0;
    hold_lik  = hold_pres ? held_lik[LikW-1:0] : '0;
    hold_kind = hold_pres ? KIND_HELD : KIND_REJECT;
    dx = $signed({x_q[CoordW-1], x_q}) - $signed({gx_q[p_q][CoordW-1], gx_q[p_q]});
    dy = $signed({y_q[CoordW-1], y_q}) - $signed({gy_q[p_q][CoordW-1], gy_q[p_q]});
    spike = (sum_q > thr_q) && !reacq;
  end

  always_comb begin
    unique case (state_q)
      ST_MDX:  mul_a = 18'(dx);
      ST_MDY:  mul_a = 18'(dy);
      default: mul_a = $signed({4'd0, desp_q, 3'd0});
    endcase
    mul_p = mul_a * mul_a;
  end

  always_comb begin
    if (mlen_q == 5'd0) len = CW'(1);
    else if ({2'b0, mlen_q} > 7'(MAX_WINDOW)) len = CW'(MAX_WINDOW);
    else len = CW'(mlen_q);
    h_eff    = (head_q[p_q] >= len) ? '0 : head_q[p_q];
    new_fill = (fill_q[p_q] < len) ? fill_q[p_q] + CW'(1) : len;
    base     = AW'(p_q) * AW'(MAX_WINDOW);
    waddr    = base + AW'(h_eff);
    iss_off  = (iss_s_q == '0) ? iss_i_q : iss_s_q - CW'(1);
    raddr    = base + AW'(iss_off);
    lo_rank  = (n_q - CW'(1)) >> 1;
    hi_rank  = n_q >> 1;
    x_less = ($signed(rd_x_q) < $signed(cand_x_q)) ||
             ((rd_x_q == cand_x_q) && (d_s_q <= d_i_q));
    y_less = ($signed(rd_y_q) < $signed(cand_y_q)) ||
             ((rd_y_q == cand_y_q) && (d_s_q <= d_i_q));
    rank_x = rank_x_q + CW'(x_less);
    rank_y = rank_y_q + CW'(y_less);
    sum_x  = $signed({lo_x_q[CoordW-1], lo_x_q}) + $signed({hi_x_q[CoordW-1], hi_x_q});
    sum_y  = $signed({lo_y_q[CoordW-1], lo_y_q}) + $signed({hi_y_q[CoordW-1], hi_y_q});
  end

  always_comb begin
    cfg_we  = cfg_valid_i && cfg_ready_o;
    new_val = cfg_data_i;
    unique case (cfg_index_i)
      REG_MODE:      begin cur_val = 14'(mode_q);  new_val = 14'(cfg_data_i[3:0]);  end
      REG_USE_CONF:  begin cur_val = 14'(use_q);   new_val = 14'(cfg_data_i[10:0]); end
      REG_DRAW_CONF: begin cur_val = 14'(draw_q);  new_val = 14'(cfg_data_i[10:0]); end
      REG_DESPIKE:   begin cur_val = 14'(desp_q);  new_val = 14'(cfg_data_i[10:0]); end
      REG_REACQ:     cur_val = reacq_q;
      REG_MED_LEN:   begin cur_val = 14'(mlen_q);  new_val = 14'(cfg_data_i[4:0]);  end
      REG_HOLD:      cur_val = hold_q;
      default:       cur_val = new_val;
    endcase
    cfg_clr = cfg_we && (cur_val != new_val) &&
              (cfg_index_i != REG_USE_CONF) && (cfg_index_i != REG_DRAW_CONF);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_PUSH) begin
      xmem[waddr] <= x_q;
      ymem[waddr] <= y_q;
    end
    rd_x_q <= xmem[raddr];
    rd_y_q <= ymem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      mode_q     <= 4'd7;
      use_q      <= 11'd205;
      draw_q     <= 11'd154;
      desp_q     <= 11'd150;
      reacq_q    <= 14'd15;
      mlen_q     <= 5'd3;
      hold_q     <= 14'd20;
      has_good_q <= '0;
      for (int k = 0; k < NUM_POINTS; k++) begin
        gx_q[k] <= '0; gy_q[k] <= '0; gf_q[k] <= '0;
        fill_q[k] <= '0; head_q[k] <= '0;
      end
      iss_on_q   <= 1'b0;
      d_vld_q    <= 1'b0;
      out_vld_q  <= 1'b0;
      out_kind_q <= KIND_REJECT;
    end else begin
      if (out_vld_q && m_axis_tready_i && (state_q != ST_EMIT)) out_vld_q <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_index_i)
          REG_MODE:      mode_q  <= cfg_data_i[3:0];
          REG_USE_CONF:  use_q   <= cfg_data_i[10:0];
          REG_DRAW_CONF: draw_q  <= cfg_data_i[10:0];
          REG_DESPIKE:   desp_q  <= cfg_data_i[10:0];
          REG_REACQ:     reacq_q <= cfg_data_i;
          REG_MED_LEN:   mlen_q  <= cfg_data_i[4:0];
          REG_HOLD:      hold_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (cfg_clr) begin
        has_good_q <= '0;
        for (int k = 0; k < NUM_POINTS; k++) begin
          gx_q[k] <= '0; gy_q[k] <= '0; gf_q[k] <= '0;
          fill_q[k] <= '0; head_q[k] <= '0;
        end
      end

      d_vld_q <= (state_q == ST_MED) && iss_on_q;

      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            inrange_q <= ({4'd0, s_axis_tuser_i} < 7'(NUM_POINTS));
            p_q       <= PW'(s_axis_tuser_i);
            frame_q   <= s_axis_tdata_i[31:0];
            pres_q    <= s_axis_tdata_i[32];
            x_q       <= s_axis_tdata_i[48:33];
            y_q       <= s_axis_tdata_i[64:49];
            lik_q     <= s_axis_tdata_i[75:65];
            state_q   <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (!mode_q[ModeFilter]) begin
            res_pres_q <= pres_q;
            res_x_q    <= pres_q ? x_q : '0;
            res_y_q    <= pres_q ? y_q : '0;
            res_lik_q  <= pres_q ? lik_q : '0;
            res_kind_q <= KIND_PASS;
            state_q    <= ST_EMIT;
          end else if (inrange_q && good0 && mode_q[ModeDespike] && has_good_q[p_q]) begin
            state_q <= ST_MDX;
          end else if (inrange_q && good0) begin
            state_q <= ST_PUSH;
          end else begin
            res_pres_q <= hold_pres;
            res_x_q    <= hold_x;
            res_y_q    <= hold_y;
            res_lik_q  <= hold_lik;
            res_kind_q <= hold_kind;
            state_q    <= ST_EMIT;
          end
        end
        ST_MDX: begin
          sum_q   <= mul_p;
          state_q <= ST_MDY;
        end
        ST_MDY: begin
          sum_q   <= sum_q + mul_p;
          state_q <= ST_MT;
        end
        ST_MT: begin
          thr_q   <= mul_p;
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          if (!spike) begin
            state_q <= ST_PUSH;
          end else begin
            res_pres_q <= hold_pres;
            res_x_q    <= hold_x;
            res_y_q    <= hold_y;
            res_lik_q  <= hold_lik;
            res_kind_q <= hold_kind;
            state_q    <= ST_EMIT;
          end
        end
        ST_PUSH: begin
          has_good_q[p_q] <= 1'b1;
          gx_q[p_q]       <= x_q;
          gy_q[p_q]       <= y_q;
          gf_q[p_q]       <= frame_q;
          head_q[p_q]     <= (h_eff + CW'(1) >= len) ? '0 : h_eff + CW'(1);
          fill_q[p_q]     <= new_fill;
          n_q             <= new_fill;
          iss_on_q        <= 1'b1;
          iss_i_q         <= '0;
          iss_s_q         <= '0;
          state_q         <= ST_MED;
        end
        ST_MED: begin
          if (iss_on_q) begin
            d_s_q   <= iss_s_q;
            d_i_q   <= iss_i_q;
            if (iss_s_q == n_q) begin
              iss_s_q <= '0;
              if (iss_i_q == n_q - CW'(1)) iss_on_q <= 1'b0;
              else iss_i_q <= iss_i_q + CW'(1);
            end else begin
              iss_s_q <= iss_s_q + CW'(1);
            end
          end
          if (d_vld_q) begin
            if (d_s_q == '0) begin
              cand_x_q <= rd_x_q;
              cand_y_q <= rd_y_q;
              rank_x_q <= '0;
              rank_y_q <= '0;
            end else begin
              rank_x_q <= rank_x;
              rank_y_q <= rank_y;
              if (d_s_q == n_q) begin
                if (rank_x == lo_rank) lo_x_q <= cand_x_q;
                if (rank_x == hi_rank) hi_x_q <= cand_x_q;
                if (rank_y == lo_rank) lo_y_q <= cand_y_q;
                if (rank_y == hi_rank) hi_y_q <= cand_y_q;
                if (d_i_q == n_q - CW'(1)) state_q <= ST_MFIN;
              end
            end
          end
        end
        ST_MFIN: begin
          res_pres_q <= 1'b1;
          res_x_q    <= sum_x[16:1];
          res_y_q    <= sum_y[16:1];
          res_lik_q  <= lik_q;
          res_kind_q <= KIND_MEDIAN;
          state_q    <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_vld_q || m_axis_tready_i) begin
            out_vld_q  <= 1'b1;
            out_pres_q <= res_pres_q;
            out_x_q    <= res_x_q;
            out_y_q    <= res_y_q;
            out_lik_q  <= res_lik_q;
            out_kind_q <= res_kind_q;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_accept_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> state_q == ST_DECIDE)
    else $error("accepted sample not decided next cycle");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (out_kind_q == KIND_REJECT) |-> m_axis_tdata_o == '0)
    else $error("rejected result carries payload");

  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MED) && iss_on_q |-> (iss_i_q < n_q) && (iss_s_q <= n_q))
    else $error("median read sequencer out of window");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MED |-> (n_q != '0) && (n_q <= CW'(MAX_WINDOW)))
    else $error("window fill out of range");
`endif

endmodule

`default_nettype wire
